// File: hw/rtl/ptrb_pkg.sv
// ----------------------------------------------------------------------------
// ptrb_pkg
// Shared constants, record layout and control types of the per-cpu trace
// ring buffer.
// ----------------------------------------------------------------------------
package ptrb_pkg;

   localparam int NUM_CPUS   = 8;
   localparam int RING_DEPTH = 64;
   localparam int SLOTS      = NUM_CPUS * RING_DEPTH;

   localparam int CPU_W  = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
   localparam int IDX_W  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int CNT_W  = $clog2(RING_DEPTH + 1);
   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   localparam int OP_W       = 2;
   localparam int REQ_DATA_W = 288;
   localparam int RSP_DATA_W = 312;

   typedef enum logic [OP_W-1:0] {
      OP_EMIT  = 2'd0,
      OP_SNAP  = 2'd1,
      OP_CLEAR = 2'd2,
      OP_NOP   = 2'd3
   } op_type;

   typedef enum logic {
      SEQ_IDLE,
      SEQ_READ
   } seq_state_type;

   typedef struct packed {
      logic [63:0] arg_b;
      logic [63:0] arg_a;
      logic [31:0] flags;
      logic [31:0] process_id;
      logic [15:0] event_id;
      logic [5:0]  cpu;
      logic [31:0] seq_num;
      logic [63:0] stamp;
   } rec_type;

   localparam int REC_W = $bits(rec_type);

   // start of a snapshot: record count, first ring index, ring base address
   typedef struct packed {
      logic [CNT_W-1:0]  cnt;
      logic [IDX_W-1:0]  ptr;
      logic [SLOT_W-1:0] base;
   } snap_cmd_type;

   typedef struct packed {
      logic valid;
      logic rec_valid;
      logic last;
   } rsp_ctl_type;

endpackage

// File: hw/rtl/ptrb_ram.sv
// ----------------------------------------------------------------------------
// ptrb_ram
// Simple dual-port synchronous ram, one write and one read port, registered
// read data that holds while no read is issued.
// ----------------------------------------------------------------------------
module ptrb_ram #(
   parameter int DATA_W = 32,
   parameter int DEPTH  = 512,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [DATA_W-1:0] wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr,
   output logic [DATA_W-1:0] rdata
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: hw/rtl/ptrb_heads.sv
// ----------------------------------------------------------------------------
// ptrb_heads
// Per-cpu head counters and the matching ring write index (head mod depth),
// updated on emit, cleared on reset op.
// ----------------------------------------------------------------------------
module ptrb_heads (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      emit,
   input  logic                      clear,
   input  logic [ptrb_pkg::CPU_W-1:0] cpu,
   output logic [31:0]               head,
   output logic [ptrb_pkg::IDX_W-1:0] hmod,
   output logic [31:0]               seq_new
);
   import ptrb_pkg::*;

   logic [31:0]      heads_ff [NUM_CPUS];
   logic [31:0]      heads_in [NUM_CPUS];
   logic [IDX_W-1:0] hmod_ff  [NUM_CPUS];
   logic [IDX_W-1:0] hmod_in  [NUM_CPUS];
   logic [IDX_W-1:0] hmod_next;

   assign head    = heads_ff[cpu];
   assign hmod    = hmod_ff[cpu];
   assign seq_new = head + 32'd1;

   // write index follows head mod depth, and restarts when the head wraps
   always_comb begin
      if (seq_new == 32'd0) begin
         hmod_next = '0;
      end else if (hmod == IDX_W'(RING_DEPTH - 1)) begin
         hmod_next = '0;
      end else begin
         hmod_next = hmod + IDX_W'(1);
      end
   end

   always_comb begin
      for (int i = 0; i < NUM_CPUS; i++) begin
         heads_in[i] = heads_ff[i];
         hmod_in[i]  = hmod_ff[i];
         if (clear) begin
            heads_in[i] = '0;
            hmod_in[i]  = '0;
         end else if (emit && (cpu == CPU_W'(i))) begin
            heads_in[i] = seq_new;
            hmod_in[i]  = hmod_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CPUS; i++) begin
            heads_ff[i] <= '0;
            hmod_ff[i]  <= '0;
         end
      end else begin
         heads_ff <= heads_in;
         hmod_ff  <= hmod_in;
      end
   end

endmodule

// File: hw/rtl/ptrb_snap_seq.sv
// ----------------------------------------------------------------------------
// ptrb_snap_seq
// Snapshot sequencer: walks one ring oldest first, one ram read per cycle;
// the ram read register is the output stage, advanced only when free.
// ----------------------------------------------------------------------------
module ptrb_snap_seq (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  ptrb_pkg::snap_cmd_type      cmd,
   input  logic                        rsp_tready,
   output logic                        idle,
   output logic                        ram_re,
   output logic [ptrb_pkg::SLOT_W-1:0] ram_raddr,
   output ptrb_pkg::rsp_ctl_type       ctl
);
   import ptrb_pkg::*;

   seq_state_type     state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [IDX_W-1:0]  ptr_ff, ptr_in;
   logic [SLOT_W-1:0] base_ff, base_in;
   logic              out_valid_ff, out_valid_in;
   logic              rec_valid_ff, rec_valid_in;
   logic              last_ff, last_in;
   logic              adv;

   assign adv       = !out_valid_ff || rsp_tready;
   assign idle      = (state_ff == SEQ_IDLE);
   assign ram_raddr = base_ff + SLOT_W'(ptr_ff);
   assign ctl       = '{valid: out_valid_ff, rec_valid: rec_valid_ff, last: last_ff};

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         SEQ_IDLE: begin
            if (start) begin
               state_in = SEQ_READ;
            end
         end
         SEQ_READ: begin
            if (adv && (cnt_ff <= CNT_W'(1))) begin
               state_in = SEQ_IDLE;
            end
         end
         default: state_in = SEQ_IDLE;
      endcase
   end

   always_comb begin
      cnt_in       = cnt_ff;
      ptr_in       = ptr_ff;
      base_in      = base_ff;
      out_valid_in = out_valid_ff;
      rec_valid_in = rec_valid_ff;
      last_in      = last_ff;
      ram_re       = 1'b0;
      if (adv) begin
         out_valid_in = 1'b0;
      end
      unique case (state_ff)
         SEQ_IDLE: begin
            if (start) begin
               cnt_in  = cmd.cnt;
               ptr_in  = cmd.ptr;
               base_in = cmd.base;
            end
         end
         SEQ_READ: begin
            if (adv) begin
               // zero count: one empty word, no read
               out_valid_in = 1'b1;
               rec_valid_in = (cnt_ff != '0);
               last_in      = (cnt_ff <= CNT_W'(1));
               ram_re       = (cnt_ff != '0);
               if (cnt_ff != '0) begin
                  cnt_in = cnt_ff - CNT_W'(1);
               end
               if (ptr_ff == IDX_W'(RING_DEPTH - 1)) begin
                  ptr_in = '0;
               end else begin
                  ptr_in = ptr_ff + IDX_W'(1);
               end
            end
         end
         default: begin
            ram_re = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SEQ_IDLE;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
         rec_valid_ff <= 1'b0;
         last_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
         rec_valid_ff <= rec_valid_in;
         last_ff      <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff  <= ptr_in;
      base_ff <= base_in;
   end

   a_empty_word: assert property (@(posedge clock) disable iff (reset)
      (state_ff == SEQ_READ && cnt_ff == '0 && adv)
      |=> (out_valid_ff && !rec_valid_ff && last_ff))
      else $error("empty snapshot did not give a single flagged word");

   a_stall_holds_walk: assert property (@(posedge clock) disable iff (reset)
      (state_ff == SEQ_READ && !adv) |=> ($stable(cnt_ff) && $stable(ptr_ff)))
      else $error("ring walk moved while output stalled");

   a_more_to_come: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !last_ff) |-> (state_ff == SEQ_READ))
      else $error("non-last word with no snapshot in progress");

   a_start_when_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> (state_ff == SEQ_IDLE))
      else $error("snapshot started while busy");

endmodule

// File: hw/rtl/per_cpu_trace_ring_buffer.sv
// ----------------------------------------------------------------------------
// per_cpu_trace_ring_buffer
// Per-cpu trace recorder: emits store timestamped records into per-cpu rings
// in one record ram, snapshots read back the newest records oldest first.
// ----------------------------------------------------------------------------
//   channel   dir   handshake                 payload
//   req_      in    req_tvalid / req_tready   tuser: op, tdata: record, cpu
//   rsp_      out   rsp_tvalid / rsp_tready   tuser: record_valid, tlast
//   csr_      in    csr_valid / csr_ready     csr_wdata: trace_enable
//
// emit, reset op and no-op are taken back to back.
// a snapshot holds the input until its last word is read, one word at a time from
// the single read port of the record ram; a stalled rsp_ side stalls it.
// the next request is taken while the last snapshot word waits on rsp_.
// reset clears heads and enable (to 1) at once; the ram needs no clearing.
// ----------------------------------------------------------------------------
module per_cpu_trace_ring_buffer (
   input  logic                                clock,
   input  logic                                reset,
   // req_tuser: op [1:0]
   // req_tdata: cpu_index [5:0], event_code [21:6], event_flags [53:22],
   //   argument_a [117:54], argument_b [181:118], timestamp [245:182],
   //   process_id [277:246], max_count [285:278], zero pad [287:286]
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [ptrb_pkg::OP_W-1:0]           req_tuser,
   input  logic [ptrb_pkg::REQ_DATA_W-1:0]     req_tdata,
   // rsp_tuser: record_valid
   // rsp_tdata: rec_stamp [63:0], rec_sequence [95:64], rec_cpu [101:96],
   //   rec_event [117:102], rec_process [149:118], rec_flags [181:150],
   //   rec_arg_a [245:182], rec_arg_b [309:246], zero pad [311:310]
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic                                rsp_tlast,
   output logic                                rsp_tuser,
   output logic [ptrb_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [0:0]                          csr_wdata
);
   import ptrb_pkg::*;

   logic              enable_ff, enable_in;
   logic              req_accept;
   op_type            op;
   logic [5:0]        cpu_raw;
   logic              in_range;
   logic [CPU_W-1:0]  cpu_s;
   logic              emit_go, clear_go, snap_go;
   logic [31:0]       head_val;
   logic [IDX_W-1:0]  hmod_val;
   logic [31:0]       seq_new;
   logic [SLOT_W-1:0] base;
   logic [SLOT_W-1:0] wr_addr;
   rec_type           wr_rec;
   rec_type           rd_rec;
   logic [CNT_W-1:0]  head_cap;
   logic [7:0]        max_count;
   logic [CNT_W-1:0]  avail_lim;
   logic [CNT_W-1:0]  avail;
   logic [CNT_W:0]    hm_w, av_w, start_w;
   snap_cmd_type      cmd;
   logic              seq_idle;
   logic              ram_re;
   logic [SLOT_W-1:0] ram_raddr;
   rsp_ctl_type       ctl;

   // ---- configuration
   assign csr_ready = 1'b1;

   always_comb begin
      enable_in = enable_ff;
      if (csr_valid) begin
         enable_in = csr_wdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b1;
      end else begin
         enable_ff <= enable_in;
      end
   end

   // ---- request decode
   assign req_tready = seq_idle;
   assign req_accept = req_tvalid && req_tready;
   assign op         = op_type'(req_tuser);
   assign cpu_raw    = req_tdata[5:0];
   assign in_range   = ({1'b0, cpu_raw} < 7'(NUM_CPUS));
   // out-of-range cpu falls back to ring 0
   assign cpu_s      = in_range ? cpu_raw[CPU_W-1:0] : '0;

   assign emit_go  = req_accept && (op == OP_EMIT) && enable_ff;
   assign clear_go = req_accept && (op == OP_CLEAR) && enable_ff;
   assign snap_go  = req_accept && (op == OP_SNAP);

   ptrb_heads u_heads (
      .clock   (clock),
      .reset   (reset),
      .emit    (emit_go),
      .clear   (clear_go),
      .cpu     (cpu_s),
      .head    (head_val),
      .hmod    (hmod_val),
      .seq_new (seq_new)
   );

   assign base    = SLOT_W'(cpu_s) * SLOT_W'(RING_DEPTH);
   assign wr_addr = base + SLOT_W'(hmod_val);

   assign wr_rec.stamp      = req_tdata[245:182];
   assign wr_rec.seq_num    = seq_new;
   assign wr_rec.cpu        = 6'(cpu_s);
   assign wr_rec.event_id   = req_tdata[21:6];
   assign wr_rec.process_id = req_tdata[277:246];
   assign wr_rec.flags      = req_tdata[53:22];
   assign wr_rec.arg_a      = req_tdata[117:54];
   assign wr_rec.arg_b      = req_tdata[181:118];

   // ---- snapshot size and first index
   assign max_count = req_tdata[285:278];
   assign head_cap  = (head_val < 32'(RING_DEPTH)) ? head_val[CNT_W-1:0]
                                                   : CNT_W'(RING_DEPTH);
   assign avail_lim = (9'(max_count) < 9'(head_cap)) ? CNT_W'(max_count) : head_cap;
   assign avail     = (enable_ff && in_range) ? avail_lim : '0;

   // (head - avail) mod depth from the tracked write index
   assign hm_w    = (CNT_W + 1)'(hmod_val);
   assign av_w    = (CNT_W + 1)'(avail);
   assign start_w = (hm_w >= av_w) ? (hm_w - av_w)
                                   : (hm_w + (CNT_W + 1)'(RING_DEPTH) - av_w);

   assign cmd.cnt  = avail;
   assign cmd.ptr  = start_w[IDX_W-1:0];
   assign cmd.base = base;

   ptrb_snap_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .start      (snap_go),
      .cmd        (cmd),
      .rsp_tready (rsp_tready),
      .idle       (seq_idle),
      .ram_re     (ram_re),
      .ram_raddr  (ram_raddr),
      .ctl        (ctl)
   );

   ptrb_ram #(
      .DATA_W (REC_W),
      .DEPTH  (SLOTS),
      .ADDR_W (SLOT_W)
   ) u_ram (
      .clock (clock),
      .we    (emit_go),
      .waddr (wr_addr),
      .wdata (wr_rec),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (rd_rec)
   );

   // ---- result word
   assign rsp_tvalid = ctl.valid;
   assign rsp_tlast  = ctl.last;
   assign rsp_tuser  = ctl.rec_valid;
   assign rsp_tdata  = ctl.rec_valid ? {2'b00, rd_rec.arg_b, rd_rec.arg_a, rd_rec.flags,
                                        rd_rec.process_id, rd_rec.event_id, rd_rec.cpu,
                                        rd_rec.seq_num, rd_rec.stamp}
                                     : '0;

endmodule
